@@ design/mlt_pkg.sv @@
// shared constants, types and sine table for the morphing lfo tremolo
package mlt_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int PHASE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int STEP_W  = 15;
  localparam int MORPH_W = 16;
  localparam int LFO_W   = 16;
  // waveforms span -32768..65536
  localparam int WAVE_W  = 18;
  localparam int MX_W    = (SAMPLE_BITS > WAVE_W) ? SAMPLE_BITS : WAVE_W;
  localparam int PROD_W  = MX_W + LFO_W;

  localparam int ROM_W      = 15;
  localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IDX_PROD_W = 16 + IDX_W;

  localparam logic [STEP_W-1:0]  STEP_RESET = 15'd22;
  localparam logic [MORPH_W-1:0] MORPH_ONE   = 16'd16384;
  localparam logic [MORPH_W-1:0] MORPH_TWO   = 16'd32768;
  localparam logic [MORPH_W-1:0] MORPH_THREE = 16'd49152;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [ROM_W-1:0] sine_rom_t [SINE_TABLE_DEPTH + 1];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAVE,
    ST_MUL_A,
    ST_MUL_B,
    ST_WET
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic wave;
    logic mul_a;
    logic mul_b;
    logic wet;
  } dp_cmd_t;

  // quarter-wave sine, taylor series in q30, rounded to q15
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint q;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = HALF_PI_Q30 * longint'(i) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x2) >> 30;
        // term k is divided by (2k)(2k+1)
        case (k)
          1: term = term / 64'd6;
          2: term = term / 64'd20;
          3: term = term / 64'd42;
          4: term = term / 64'd72;
          5: term = term / 64'd110;
          6: term = term / 64'd156;
          default: term = term / 64'd210;
        endcase
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      q = (sum + 64'sd16384) >>> 15;
      if (q > 64'sd32767) q = 64'sd32767;
      if (q < 64'sd0) q = 64'sd0;
      rom[i] = ROM_W'(q);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ design/mlt_ctrl.sv @@
// sequencer for accept, waveform, two mix multiplies and the wet multiply
module mlt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mlt_pkg::dp_cmd_t cmd_o
);
  import mlt_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WAVE;
        end
      end
      ST_WAVE: begin
        cmd_o.wave = 1'b1;
        state_d    = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_WET;
      end
      ST_WET: begin
        // hold until the output slot is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.wet   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/mlt_datapath.sv @@
// phase accumulator, waveform generation, shared multiplier and output registers
module mlt_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mlt_pkg::dp_cmd_t                      cmd_i,
  input  logic                                  cfg_we_i,
  input  logic [mlt_pkg::STEP_W-1:0]            cfg_wdata_i,
  input  logic signed [mlt_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [mlt_pkg::MORPH_W-1:0]           morph_i,
  output logic signed [mlt_pkg::SAMPLE_BITS-1:0] dry_out_o,
  output logic signed [mlt_pkg::SAMPLE_BITS-1:0] wet_out_o,
  output logic signed [mlt_pkg::LFO_W-1:0]      lfo_value_o
);
  import mlt_pkg::*;

  logic [PHASE_BITS-1:0]         phase_q;
  logic [STEP_W-1:0]             step_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [MORPH_W-1:0]            morph_q;
  logic signed [WAVE_W-1:0]      wa_q, wb_q, wa_d, wb_d;
  logic signed [LFO_W-1:0]       w1_q, w2_q, w1_d, w2_d;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [LFO_W-1:0]       lfo_q, lfo_d;
  logic signed [SAMPLE_BITS-1:0] dry_q, wet_q, wet_d;
  logic signed [LFO_W-1:0]       lfo_out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= STEP_RESET;
    end else begin
      if (cfg_we_i) step_q <= cfg_wdata_i;
      if (cmd_i.load) phase_q <= phase_q + PHASE_BITS'(step_q);
    end
  end

  // waveforms from the top 16 phase bits
  logic [PHASE_BITS+15:0]   phase_ext;
  logic signed [15:0]       p;
  logic [15:0]              absp, fold;
  logic [IDX_PROD_W-1:0]    scaled;
  logic [IDX_W-1:0]         idx;
  logic [WAVE_W-1:0]        sine_mag;
  logic signed [WAVE_W-1:0] sine, tri_wave, sq, saw;

  assign phase_ext = {phase_q, 16'b0};
  assign p         = signed'(phase_ext[PHASE_BITS+15 -: 16]);
  assign absp      = p[15] ? 16'(-p) : 16'(p);
  assign fold      = (absp > 16'd16384) ? (16'd32768 - absp) : absp;
  assign scaled    = IDX_PROD_W'(fold) * IDX_PROD_W'(SINE_TABLE_DEPTH) + IDX_PROD_W'(8192);
  assign idx       = scaled[14 +: IDX_W];
  assign sine_mag  = WAVE_W'(SINE_ROM[idx]);
  assign sine      = p[15] ? -signed'(sine_mag) : signed'(sine_mag);
  assign tri_wave  = signed'({1'b0, absp, 1'b0}) - 18'sd32768;
  assign sq        = (!p[15] && (p != 16'sd0)) ? 18'sd32768 : -18'sd32768;
  assign saw       = 18'sd32768 - WAVE_W'(p);

  // crossfade region select
  always_comb begin
    if (morph_q <= MORPH_ONE) begin
      w1_d = signed'(MORPH_ONE - morph_q);
      w2_d = signed'(morph_q);
      wa_d = sine;
      wb_d = tri_wave;
    end else if (morph_q <= MORPH_TWO) begin
      w1_d = signed'(MORPH_TWO - morph_q);
      w2_d = signed'(morph_q - MORPH_ONE);
      wa_d = tri_wave;
      wb_d = sq;
    end else if (morph_q <= MORPH_THREE) begin
      w1_d = signed'(MORPH_THREE - morph_q);
      w2_d = signed'(morph_q - MORPH_TWO);
      wa_d = sq;
      wb_d = saw;
    end else begin
      w1_d = '0;
      w2_d = '0;
      wa_d = '0;
      wb_d = '0;
    end
  end

  // one multiplier shared by both mix terms and the wet product
  logic signed [MX_W-1:0]   mul_x;
  logic signed [LFO_W-1:0]  mul_y;
  logic signed [PROD_W-1:0] product;

  always_comb begin
    mul_x = MX_W'(wa_q);
    mul_y = w1_q;
    if (cmd_i.mul_b) begin
      mul_x = MX_W'(wb_q);
      mul_y = w2_q;
    end else if (cmd_i.wet) begin
      mul_x = MX_W'(sample_q);
      mul_y = lfo_q;
    end
  end

  assign product = PROD_W'(mul_x) * PROD_W'(mul_y);

  // mix sum, round to q15, saturate
  logic signed [PROD_W:0] mix_sum, mix_rnd;
  assign mix_sum = (PROD_W+1)'(prod_q) + (PROD_W+1)'(product);
  assign mix_rnd = (mix_sum + (PROD_W+1)'(8192)) >>> 14;

  always_comb begin
    if ((&mix_rnd[PROD_W:15]) || !(|mix_rnd[PROD_W:15])) lfo_d = mix_rnd[15:0];
    else if (mix_rnd[PROD_W]) lfo_d = 16'sh8000;
    else lfo_d = 16'sh7fff;
  end

  // wet product round and saturate
  logic signed [PROD_W-1:0] wet_rnd;
  assign wet_rnd = (product + PROD_W'(16384)) >>> 15;

  always_comb begin
    if ((&wet_rnd[PROD_W-1:SAMPLE_BITS-1]) || !(|wet_rnd[PROD_W-1:SAMPLE_BITS-1])) begin
      wet_d = wet_rnd[SAMPLE_BITS-1:0];
    end else if (wet_rnd[PROD_W-1]) begin
      wet_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      wet_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_in_i;
      morph_q  <= morph_i;
    end
    if (cmd_i.wave) begin
      wa_q <= wa_d;
      wb_q <= wb_d;
      w1_q <= w1_d;
      w2_q <= w2_d;
    end
    if (cmd_i.mul_a) prod_q <= product;
    if (cmd_i.mul_b) lfo_q <= lfo_d;
    if (cmd_i.wet) begin
      dry_q     <= sample_q;
      wet_q     <= wet_d;
      lfo_out_q <= lfo_q;
    end
  end

  assign dry_out_o   = dry_q;
  assign wet_out_o   = wet_q;
  assign lfo_value_o = lfo_out_q;

endmodule

@@ design/morphing_lfo_tremolo_unit.sv @@
// top level of the morphing lfo tremolo
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------
//  input    | in_valid_i / in_ready_o  | sample_in_i, morph_i
//  output   | out_valid_o / out_ready_i| dry_out_o, wet_out_o, lfo_value_o
//  config   | cfg_we_i                 | cfg_wdata_i (phase step)
//
// one sample goes through accept, waveform and rom lookup, then three passes
// through the single shared multiplier (two mix terms, then the wet product)
// a result sits in the output register while the next sample is accepted
// when the output register is still full the wet step holds until it drains
// reset clears the phase, sets the phase step to 22 and empties the output
module morphing_lfo_tremolo_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mlt_pkg::STEP_W-1:0]            cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [mlt_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [mlt_pkg::MORPH_W-1:0]           morph_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mlt_pkg::SAMPLE_BITS-1:0] dry_out_o,
  output logic signed [mlt_pkg::SAMPLE_BITS-1:0] wet_out_o,
  output logic signed [mlt_pkg::LFO_W-1:0]      lfo_value_o
);
  import mlt_pkg::*;

  dp_cmd_t cmd;

  mlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  mlt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_in_i (sample_in_i),
    .morph_i     (morph_i),
    .dry_out_o   (dry_out_o),
    .wet_out_o   (wet_out_o),
    .lfo_value_o (lfo_value_o)
  );

  // at most one datapath step per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.wave, cmd.mul_a, cmd.mul_b, cmd.wet}))
    else $error("more than one datapath step issued");

  // an accepted beat blocks further input while it is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a sample is in flight");

  // a new result only appears after the wet step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.wet))
    else $error("output became valid without a wet step");

  // the wet step never overwrites a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wet |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

endmodule

@@ tb/mlt_checker.sv @@
// checker for the morphing lfo tremolo: predicts each result beat and compares it
`timescale 1ns / 100ps

module mlt_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mlt_pkg::STEP_W-1:0]             cfg_wdata_i,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_i,
  input  logic signed [mlt_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [mlt_pkg::MORPH_W-1:0]            morph_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_ready_i,
  input  logic signed [mlt_pkg::SAMPLE_BITS-1:0] dry_out_i,
  input  logic signed [mlt_pkg::SAMPLE_BITS-1:0] wet_out_i,
  input  logic signed [mlt_pkg::LFO_W-1:0]       lfo_value_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);
  import mlt_pkg::*;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] dry;
    logic signed [SAMPLE_BITS-1:0] wet;
    logic signed [LFO_W-1:0]       lfo;
  } tremolo_result_t;

  tremolo_result_t           pending_results [$];
  tremolo_result_t           want;
  int                        sine_tab [SINE_TABLE_DEPTH + 1];
  logic [PHASE_BITS-1:0]     phase_acc;
  logic [STEP_W-1:0]         step_now;
  longint                    wet_full;

  // quarter-wave table, taylor series in q30 then rounded to q15
  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          q;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = HALF_PI_Q30 * longint'(i) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      q = (acc + 16384) >>> 15;
      sine_tab[i] = (q > 32767) ? 32767 : ((q < 0) ? 0 : int'(q));
    end
  end

  function automatic logic signed [LFO_W-1:0] morph_lfo(
    input logic signed [15:0] p,
    input logic [MORPH_W-1:0] m
  );
    longint pa;
    longint ang;
    longint idx;
    longint sn;
    longint tri_w;
    longint sq_w;
    longint saw_w;
    longint mm;
    longint acc;
    longint lv;
    pa = (p < 0) ? -longint'(p) : longint'(p);
    ang = (pa > 16384) ? 32768 - pa : pa;
    idx = (ang * SINE_TABLE_DEPTH + 8192) / 16384;
    if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
    sn = (p < 0) ? -longint'(sine_tab[idx]) : longint'(sine_tab[idx]);
    // waveforms in q15 with 1.0 = 32768, saw reaches 65536 at -pi
    tri_w = -32768 + 2 * pa;
    sq_w = (p > 0) ? 32768 : -32768;
    saw_w = 32768 - longint'(p);
    mm = longint'(m);
    if (mm <= longint'(MORPH_ONE)) begin
      acc = (16384 - mm) * sn + mm * tri_w;
    end else if (mm <= longint'(MORPH_TWO)) begin
      acc = (32768 - mm) * tri_w + (mm - 16384) * sq_w;
    end else if (mm <= longint'(MORPH_THREE)) begin
      acc = (49152 - mm) * sq_w + (mm - 32768) * saw_w;
    end else begin
      acc = 0;
    end
    lv = (acc + 8192) >>> 14;
    if (lv > 32767) lv = 32767;
    if (lv < -32768) lv = -32768;
    return LFO_W'(lv);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc = '0;
      step_now = STEP_RESET;
      pending_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) step_now = cfg_wdata_i;

      if (in_valid_i && in_ready_i) begin
        phase_acc = phase_acc + PHASE_BITS'(step_now);
        want.dry = sample_in_i;
        want.lfo = morph_lfo(signed'(phase_acc[PHASE_BITS-1 -: 16]), morph_i);
        wet_full = (longint'(sample_in_i) * longint'(want.lfo) + 16384) >>> 15;
        if (wet_full > 32767) wet_full = 32767;
        if (wet_full < -32768) wet_full = -32768;
        want.wet = SAMPLE_BITS'(wet_full);
        pending_results.push_back(want);
      end

      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no sample waiting for it");
          fail_count_o++;
        end else begin
          want = pending_results.pop_front();
          if (dry_out_i !== want.dry) begin
            $error("dry_out: expected %0d, got %0d", want.dry, dry_out_i);
            fail_count_o++;
          end
          if (wet_out_i !== want.wet) begin
            $error("wet_out: expected %0d, got %0d", want.wet, wet_out_i);
            fail_count_o++;
          end
          if (lfo_value_i !== want.lfo) begin
            $error("lfo_value: expected %0d, got %0d", want.lfo, lfo_value_i);
            fail_count_o++;
          end
        end
      end

      pending_o = pending_results.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// testbench top for the morphing lfo tremolo: stimulus, clock, reset and verdict
`timescale 1ns / 100ps

module tb;
  import mlt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int RUN_SETTINGS = 6;
  localparam int RUN_ITEMS = 1725;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [STEP_W-1:0]             cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_in_i = '0;
  logic [MORPH_W-1:0]            morph_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] dry_out_o;
  logic signed [SAMPLE_BITS-1:0] wet_out_o;
  logic signed [LFO_W-1:0]       lfo_value_o;

  int  fail_count;
  int  pending;
  int  cycle_count = 0;
  int  samples_sent = 0;
  int  step_writes = 0;
  bit  long_hold_req = 1'b0;

  // step 16384 walks the phase through -pi/2, 0, pi/2, -pi
  logic signed [15:0] dir_sample [16] = '{
    16'sh7fff, -16'sd1, 16'sd1, 16'sh8000, 16'sh8000, 16'sh7fff, -16'sd32767, 16'sd12345,
    16'sh7fff, 16'sh8000, 16'sd0, 16'sh7fff, -16'sd20000, 16'sd20000, -16'sd1, 16'sh8000
  };
  logic [15:0] dir_morph [16] = '{
    16'd0, 16'd0, 16'd16384, 16'd0, 16'd32768, 16'd32768, 16'd32769, 16'd49152,
    16'd49153, 16'd65535, 16'd16385, 16'd40960, 16'd8192, 16'd24576, 16'd40960, 16'd16384
  };

  morphing_lfo_tremolo_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .morph_i     (morph_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dry_out_o   (dry_out_o),
    .wet_out_o   (wet_out_o),
    .lfo_value_o (lfo_value_o)
  );

  mlt_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .morph_i      (morph_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dry_out_i    (dry_out_o),
    .wet_out_i    (wet_out_o),
    .lfo_value_i  (lfo_value_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_sample(input logic signed [15:0] s, input logic [15:0] m,
                             input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_in_i = s;
    morph_i = m;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
  endtask

  // only once every sample has come back out
  task automatic write_step(input logic [STEP_W-1:0] v);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    step_writes++;
  endtask

  // output side: random back-pressure, quiet stretches, one long hold on request
  initial begin
    int rx_gap;
    int rx_cycles;
    rx_gap = 0;
    rx_cycles = 0;
    forever begin
      @(negedge clk_i);
      rx_cycles++;
      if (long_hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (rx_gap > 0) begin
        out_ready_i = 1'b0;
        rx_gap--;
      end else begin
        out_ready_i = 1'b1;
        rx_gap = pick_gap((rx_cycles / 512) % 3 == 0);
      end
    end
  end

  initial begin
    logic [15:0] boundary [8];
    logic [15:0] edge_sample [4];
    logic [STEP_W-1:0] run_step [RUN_SETTINGS];
    logic signed [15:0] s;
    logic [15:0] m;
    int per_setting;
    int r;

    boundary = '{16'd0, 16'd16384, 16'd16385, 16'd32768,
                 16'd32769, 16'd49152, 16'd49153, 16'd65535};
    edge_sample = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset phase step of 22, phase ends at 44
    push_sample(16'sh7fff, 16'd0, 0);
    push_sample(16'sh8000, 16'd8192, 1);
    // lands the phase on -pi, saw overshoot
    write_step(15'd32724);
    push_sample(16'sh8000, 16'd49152, 0);

    write_step(15'd16384);
    for (int i = 0; i < 16; i++) begin
      push_sample(dir_sample[i], dir_morph[i], $urandom_range(0, 2));
    end

    write_step(15'd0);
    push_sample(16'sh7fff, 16'd32768, 0);
    push_sample(16'sd1, 16'd0, 0);

    write_step(15'h7fff);
    push_sample(16'sh8000, 16'd49152, 0);
    push_sample(16'sh7fff, 16'd16384, 0);
    push_sample(-16'sd1234, 16'd0, 0);

    run_step = '{15'd1, 15'h7fff, 15'($urandom), 15'($urandom_range(1, 64)),
                 STEP_RESET, 15'($urandom)};
    per_setting = RUN_ITEMS / RUN_SETTINGS;
    for (int k = 0; k < RUN_SETTINGS; k++) begin
      write_step(run_step[k]);
      for (int n = 0; n < per_setting; n++) begin
        // fill the block while the output side is held off
        if (k == 1 && n == 100) long_hold_req = 1'b1;
        r = $urandom_range(0, 9);
        if (r == 0) m = boundary[$urandom_range(0, 7)];
        else if (r == 1) m = 16'($urandom_range(49153, 65535));
        else m = 16'($urandom_range(0, 49152));
        s = ($urandom_range(0, 9) == 0) ? signed'(edge_sample[$urandom_range(0, 3)])
                                        : signed'(16'($urandom));
        push_sample(s, m, pick_gap((n / 64) % 3 == 0 || long_hold_req));
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("run: %0d samples over %0d phase step writes, all morph regions and silence",
             samples_sent, step_writes);
    $display("run: phase at -pi, zero and both signs, saturated lfo and wet, long output stall");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/mlt_pkg.sv
design/mlt_ctrl.sv
design/mlt_datapath.sv
design/morphing_lfo_tremolo_unit.sv
tb/mlt_checker.sv
tb/tb.sv
